FILE: rtl/core/pdde_pkg.sv
// Shared types and constants for the page descriptor decode/encode block.
// Holds the request and result beat layouts, descriptor type codes and
// the request classification used between the pipeline stages.
package pdde_pkg;

  // First-level descriptor type, bits 1..0
  localparam logic [1:0] L1_FAULT    = 2'b00;
  localparam logic [1:0] L1_COARSE   = 2'b01;
  localparam logic [1:0] L1_SECTION  = 2'b10;
  localparam logic [1:0] L1_RESERVED = 2'b11;

  // Second-level descriptor type, bits 1..0 (1x is a small page)
  localparam logic [1:0] L2_FAULT = 2'b00;
  localparam logic [1:0] L2_LARGE = 2'b01;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_REFUSED  = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;

  // Page sizes as log2
  localparam logic [4:0] SZ_4K  = 5'd12;
  localparam logic [4:0] SZ_64K = 5'd16;
  localparam logic [4:0] SZ_1M  = 5'd20;
  localparam logic [4:0] SZ_16M = 5'd24;

  // Request classes resolved in the first stage
  typedef enum logic [3:0] {
    K_L1_FAULT,
    K_L1_RESERVED,
    K_L2_FAULT,
    K_LARGE,
    K_SMALL,
    K_SECTION,
    K_SUPER,
    K_ENC_REFUSE,
    K_ENC_UNMAP,
    K_ENC_MAP
  } kind_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] virt_addr;
    logic [31:0] first_level_desc;
    logic [31:0] second_level_desc;
    logic [31:0] frame_in;
    logic [2:0]  perm_in;
    logic        exec_in;
    logic        global_in;
    logic        shared_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  size_log2;
    logic [2:0]  domain;
    logic [2:0]  perm_out;
    logic        exec_out;
    logic        global_out;
    logic        shared_out;
    logic [39:0] frame_out;
    logic [39:0] phys_addr;
    logic [31:0] new_desc;
  } res_t;

endpackage

FILE: rtl/core/pdde_if.sv
// Valid/ready channel interfaces for the page descriptor decode/encode block.
// Request and response beats carry the payload fields by name; no package use.
interface pdde_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] virt_addr;
  logic [31:0] first_level_desc;
  logic [31:0] second_level_desc;
  logic [31:0] frame_in;
  logic [2:0]  perm_in;
  logic        exec_in;
  logic        global_in;
  logic        shared_in;

  modport source (
    output valid, req_type, virt_addr, first_level_desc, second_level_desc,
           frame_in, perm_in, exec_in, global_in, shared_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, virt_addr, first_level_desc, second_level_desc,
           frame_in, perm_in, exec_in, global_in, shared_in,
    output ready
  );
endinterface

interface pdde_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  size_log2;
  logic [2:0]  domain;
  logic [2:0]  perm_out;
  logic        exec_out;
  logic        global_out;
  logic        shared_out;
  logic [39:0] frame_out;
  logic [39:0] phys_addr;
  logic [31:0] new_desc;

  modport source (
    output valid, status, size_log2, domain, perm_out, exec_out, global_out,
           shared_out, frame_out, phys_addr, new_desc,
    input  ready
  );
  modport sink (
    input  valid, status, size_log2, domain, perm_out, exec_out, global_out,
           shared_out, frame_out, phys_addr, new_desc,
    output ready
  );
endinterface

FILE: rtl/core/pdde_fields.sv
// Second-stage field builder: turns a classified request into result fields.
// phys_addr leaves here as the page base; the page offset is merged later.
// Depends on pdde_pkg.
module pdde_fields (
  input  pdde_pkg::req_t  req,
  input  pdde_pkg::kind_t kind,
  output pdde_pkg::res_t  res,
  output logic            mapped
);

  logic [31:0] d1;
  logic [31:0] d2;
  logic [2:0]  l1_dom;
  logic [2:0]  l1_ap;
  logic [2:0]  l2_ap;
  logic [31:0] enc_desc;

  assign d1     = req.first_level_desc;
  assign d2     = req.second_level_desc;
  assign l1_dom = d1[7:5];
  assign l1_ap  = {d1[15], d1[11:10]};
  assign l2_ap  = {d2[9], d2[5:4]};

  // Pack a small-page descriptor: nG, S, APX, AP, type 1x, XN
  assign enc_desc = {req.frame_in[31:12], ~req.global_in, req.shared_in,
                     req.perm_in[2], 3'b000, req.perm_in[1:0], 2'b00,
                     1'b1, ~req.exec_in};

  // Select result fields per class
  always_comb begin
    res           = '0;
    res.exec_out  = 1'b1;
    res.size_log2 = pdde_pkg::SZ_4K;
    res.status    = pdde_pkg::ST_OK;
    mapped        = 1'b0;
    case (kind)
      pdde_pkg::K_L1_FAULT: begin
        res.status    = pdde_pkg::ST_UNMAPPED;
        res.size_log2 = pdde_pkg::SZ_1M;
      end
      pdde_pkg::K_L1_RESERVED: begin
        res.status    = pdde_pkg::ST_INVALID;
        res.size_log2 = pdde_pkg::SZ_1M;
      end
      pdde_pkg::K_L2_FAULT: begin
        res.status = pdde_pkg::ST_UNMAPPED;
        res.domain = l1_dom;
      end
      pdde_pkg::K_LARGE: begin
        res.size_log2  = pdde_pkg::SZ_64K;
        res.domain     = l1_dom;
        res.perm_out   = l2_ap;
        res.exec_out   = ~d2[15];
        res.shared_out = d2[10];
        res.frame_out  = {8'h00, d2[31:16], 16'h0000};
        mapped         = 1'b1;
      end
      pdde_pkg::K_SMALL: begin
        res.domain     = l1_dom;
        res.perm_out   = l2_ap;
        res.exec_out   = ~d2[0];
        res.global_out = ~d2[11];
        res.shared_out = d2[10];
        res.frame_out  = {8'h00, d2[31:12], 12'h000};
        mapped         = 1'b1;
      end
      pdde_pkg::K_SECTION: begin
        res.size_log2 = pdde_pkg::SZ_1M;
        res.domain    = l1_dom;
        res.perm_out  = l1_ap;
        res.frame_out = {8'h00, d1[31:20], 20'h00000};
        mapped        = 1'b1;
      end
      pdde_pkg::K_SUPER: begin
        res.size_log2 = pdde_pkg::SZ_16M;
        res.perm_out  = l1_ap;
        res.frame_out = {d1[8:5], d1[23:20], d1[31:24], 24'h000000};
        mapped        = 1'b1;
      end
      pdde_pkg::K_ENC_REFUSE: begin
        res.status   = pdde_pkg::ST_REFUSED;
        res.exec_out = 1'b0;
        res.new_desc = d2;
      end
      pdde_pkg::K_ENC_UNMAP: begin
        res.exec_out = 1'b0;
      end
      pdde_pkg::K_ENC_MAP: begin
        res.exec_out = 1'b0;
        res.new_desc = enc_desc;
      end
      default: begin
        res.exec_out = 1'b1;
      end
    endcase
    res.phys_addr = res.frame_out;
  end

endmodule

FILE: rtl/core/page_descriptor_decode_encode_top.sv
// Top level of the page descriptor decode/encode block: three-stage pipeline.
// Depends on pdde_pkg, pdde_if (pdde_req_if, pdde_rsp_if) and pdde_fields.
//
// Usage:
//   req (sink): one beat per lookup. req_type 0 decodes the fetched
//   first- and second-level descriptors for virt_addr; req_type 1 builds a
//   small-page descriptor from frame_in, perm_in and the attribute bits,
//   refusing when the current second-level entry is a large page.
//   rsp (source): exactly one result beat per request beat, in order.
//   An accepted request is registered in stage 1, then stage 2, then stage 3,
//   whose register drives the rsp beat and rsp.valid. Stage 1 classifies the
//   descriptors, stage 2 selects the fields and builds the new descriptor,
//   stage 3 merges the page offset into the frame base.
//   Throughput is one beat per cycle while rsp.ready stays high; every stage holds its own valid bit.
//   When the receiver stalls, stages fill from the output backward and
//   req.ready drops only once all three stages hold a beat; a bubble in
//   any stage is filled while the output is held.
//   Synchronous reset (rst) clears all valid bits; payload is not reset.
module page_descriptor_decode_encode_top (
  input logic       clk,
  input logic       rst,
  pdde_req_if.sink  req,
  pdde_rsp_if.source rsp
);

  pdde_pkg::req_t  in_req;
  pdde_pkg::kind_t in_kind;

  logic            s1_valid;
  pdde_pkg::req_t  s1_req;
  pdde_pkg::kind_t s1_kind;
  logic            s1_ready;

  pdde_pkg::res_t  s2_res_next;
  logic            s2_mapped_next;
  logic            s2_valid;
  pdde_pkg::res_t  s2_res;
  logic            s2_mapped;
  logic [31:0]     s2_va;
  logic            s2_ready;

  logic [31:0]     s3_offset;
  pdde_pkg::res_t  s3_res_next;
  logic            s3_valid;
  pdde_pkg::res_t  s3_res;
  logic            s3_ready;

  // Gather request beat fields
  assign in_req = '{
    req_type:          req.req_type,
    virt_addr:         req.virt_addr,
    first_level_desc:  req.first_level_desc,
    second_level_desc: req.second_level_desc,
    frame_in:          req.frame_in,
    perm_in:           req.perm_in,
    exec_in:           req.exec_in,
    global_in:         req.global_in,
    shared_in:         req.shared_in
  };

  // Backpressure: a stage takes a beat when empty or when it drains
  assign s3_ready  = !s3_valid || rsp.ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign req.ready = s1_ready;

  // Stage 1: classify the request
  always_comb begin
    in_kind = pdde_pkg::K_L1_FAULT;
    if (in_req.req_type) begin
      if (in_req.second_level_desc[1:0] == pdde_pkg::L2_LARGE) begin
        in_kind = pdde_pkg::K_ENC_REFUSE;
      end else if (in_req.frame_in == 32'h0) begin
        in_kind = pdde_pkg::K_ENC_UNMAP;
      end else begin
        in_kind = pdde_pkg::K_ENC_MAP;
      end
    end else begin
      case (in_req.first_level_desc[1:0])
        pdde_pkg::L1_FAULT: begin
          in_kind = pdde_pkg::K_L1_FAULT;
        end
        pdde_pkg::L1_COARSE: begin
          case (in_req.second_level_desc[1:0])
            pdde_pkg::L2_FAULT: in_kind = pdde_pkg::K_L2_FAULT;
            pdde_pkg::L2_LARGE: in_kind = pdde_pkg::K_LARGE;
            default:            in_kind = pdde_pkg::K_SMALL;
          endcase
        end
        pdde_pkg::L1_SECTION: begin
          in_kind = in_req.first_level_desc[18] ? pdde_pkg::K_SUPER
                                                : pdde_pkg::K_SECTION;
        end
        default: begin
          in_kind = pdde_pkg::K_L1_RESERVED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && req.valid) begin
      s1_req  <= in_req;
      s1_kind <= in_kind;
    end
  end

  // Stage 2: build result fields
  pdde_fields u_fields (
    .req    (s1_req),
    .kind   (s1_kind),
    .res    (s2_res_next),
    .mapped (s2_mapped_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_res    <= s2_res_next;
      s2_mapped <= s2_mapped_next;
      s2_va     <= s1_req.virt_addr;
    end
  end

  // Stage 3: merge the page offset into the base
  always_comb begin
    case (s2_res.size_log2)
      pdde_pkg::SZ_64K: s3_offset = {16'h0000, s2_va[15:0]};
      pdde_pkg::SZ_1M:  s3_offset = {12'h000, s2_va[19:0]};
      pdde_pkg::SZ_16M: s3_offset = {8'h00, s2_va[23:0]};
      default:          s3_offset = {20'h00000, s2_va[11:0]};
    endcase
    if (!s2_mapped) begin
      s3_offset = 32'h0;
    end
    s3_res_next           = s2_res;
    s3_res_next.phys_addr = s2_res.phys_addr | {8'h00, s3_offset};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_res <= s3_res_next;
    end
  end

  // Drive the response beat
  assign rsp.valid      = s3_valid;
  assign rsp.status     = s3_res.status;
  assign rsp.size_log2  = s3_res.size_log2;
  assign rsp.domain     = s3_res.domain;
  assign rsp.perm_out   = s3_res.perm_out;
  assign rsp.exec_out   = s3_res.exec_out;
  assign rsp.global_out = s3_res.global_out;
  assign rsp.shared_out = s3_res.shared_out;
  assign rsp.frame_out  = s3_res.frame_out;
  assign rsp.phys_addr  = s3_res.phys_addr;
  assign rsp.new_desc   = s3_res.new_desc;

`ifndef ASSERT_OFF
  // A beat leaving stage 1 lands in stage 2
  a_s1_to_s2: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready |=> s2_valid)
    else $error("stage 1 beat lost on advance");

  // A held output beat keeps stage 2 and stage 3 full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    s3_valid && !rsp.ready && s2_valid |=> s3_valid && s2_valid)
    else $error("beat dropped while output stalled");

  // Only a mapped result carries a translated address
  a_phys_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != pdde_pkg::ST_OK |-> rsp.phys_addr == 40'h0)
    else $error("phys_addr set on unmapped result");

  // Merging the page offset never clears the frame base bits
  a_frame_in_phys: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.phys_addr & rsp.frame_out) == rsp.frame_out)
    else $error("phys_addr does not cover frame base");
`endif

endmodule
